// ===== design/rsas_pkg.sv =====
// Shared constants and types for the rotated sorted array search block.
package rsas_pkg;

  localparam int DEPTH      = 4096;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int INDEX_BITS = 12;
  localparam int DATA_BITS  = 32;
  localparam int OUT_BITS   = 16;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    value_t wdata;
    addr_t raddr;
  } store_req_t;

endpackage

// ===== design/rsas_store.sv =====
// Element store: one write port, one read port with registered read data.
module rsas_store (
  input  logic                clk,
  input  rsas_pkg::store_req_t req,
  output rsas_pkg::value_t     rdata
);
  import rsas_pkg::*;

  value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== design/rotated_sorted_array_search.sv =====
// Top level: loads a rotated sorted array and binary searches it for targets.
//
//  channel  dir  tdata                          tuser        tlast
//  s_*      in   [31:0] value                   kind         last
//  m_*      out  [0] found, [12:1] index        -            -
//
//  A search is accepted, then reads the pivot range (up to 4 reads) and runs
//  binary search steps of a read and a compare each (up to 13, plus the closing
//  bound check), all through the single read port of the element store; a final
//  state hands the result to the output register.
//  Items are taken only between searches.
//  rst clears the array bookkeeping; the element store itself is not cleared.
//  A result held by m_tready low stalls only the end of the next search.
module rotated_sorted_array_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] kind
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] found, [12:1] index, [15:13] zero
);
  import rsas_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ONE    = 4'd1;
  localparam logic [3:0] ST_MIN    = 4'd2;
  localparam logic [3:0] ST_MAX    = 4'd3;
  localparam logic [3:0] ST_FIRST  = 4'd4;
  localparam logic [3:0] ST_LAST   = 4'd5;
  localparam logic [3:0] ST_ISSUE  = 4'd6;
  localparam logic [3:0] ST_CMP    = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;

  logic [3:0] state, state_next;
  cnt_t   count, count_next;
  addr_t  pivot, pivot_next;
  logic   descent, descent_next;
  logic   complete, complete_next;
  value_t prev, prev_next;
  value_t target, target_next;
  cnt_t   lo, lo_next;
  addr_t  hi, hi_next;
  addr_t  mid, mid_next;
  logic   found, found_next;
  logic [INDEX_BITS-1:0] index, index_next;
  logic   out_valid, out_valid_next;
  logic [OUT_BITS-1:0] out_data, out_data_next;

  store_req_t req;
  value_t     rdata;
  value_t     key;
  cnt_t       cnt_eff;
  logic       desc_eff;
  logic       accept;
  logic [ADDR_BITS:0] mid_sum;

  rsas_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign key      = s_tdata[VALUE_BITS-1:0];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign cnt_eff  = complete ? '0 : count;
  assign desc_eff = complete ? 1'b0 : descent;
  assign mid_sum  = {1'b0, lo[ADDR_BITS-1:0]} + {1'b0, hi};
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_comb begin
    state_next     = state;
    count_next     = count;
    pivot_next     = pivot;
    descent_next   = descent;
    complete_next  = complete;
    prev_next      = prev;
    target_next    = target;
    lo_next        = lo;
    hi_next        = hi;
    mid_next       = mid;
    found_next     = found;
    index_next     = index;
    out_valid_next = out_valid && !m_tready;
    out_data_next  = out_data;
    req.we         = 1'b0;
    req.waddr      = cnt_eff[ADDR_BITS-1:0];
    req.wdata      = key;
    req.raddr      = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept && s_tuser == KIND_LOAD) begin
          complete_next = s_tlast;
          if (complete) begin
            count_next   = '0;
            pivot_next   = '0;
            descent_next = 1'b0;
          end
          if (cnt_eff < CNT_BITS'(DEPTH)) begin
            if (cnt_eff != '0 && !desc_eff && prev > key) begin
              pivot_next   = ADDR_BITS'(cnt_eff - CNT_BITS'(1));
              descent_next = 1'b1;
            end
            req.we     = 1'b1;
            prev_next  = key;
            count_next = cnt_eff + CNT_BITS'(1);
          end
        end else if (accept) begin
          target_next = key;
          found_next  = 1'b0;
          index_next  = '0;
          if (count == '0) begin
            state_next = ST_FIN;
          end else if (count == CNT_BITS'(1)) begin
            req.raddr  = '0;
            state_next = ST_ONE;
          end else if (!descent) begin
            lo_next    = '0;
            hi_next    = ADDR_BITS'(count - CNT_BITS'(1));
            state_next = ST_ISSUE;
          end else begin
            req.raddr  = pivot + ADDR_BITS'(1);
            state_next = ST_MIN;
          end
        end
      end
      ST_ONE: begin
        found_next = (rdata == target);
        state_next = ST_FIN;
      end
      ST_MIN: begin
        if (target < rdata) begin
          state_next = ST_FIN;
        end else begin
          req.raddr  = pivot;
          state_next = ST_MAX;
        end
      end
      ST_MAX: begin
        if (target > rdata) begin
          state_next = ST_FIN;
        end else begin
          req.raddr  = '0;
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (target >= rdata) begin
          lo_next    = '0;
          hi_next    = pivot;
          state_next = ST_ISSUE;
        end else begin
          req.raddr  = ADDR_BITS'(count - CNT_BITS'(1));
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        if (target <= rdata) begin
          lo_next    = CNT_BITS'(pivot) + CNT_BITS'(1);
          hi_next    = ADDR_BITS'(count - CNT_BITS'(1));
          state_next = ST_ISSUE;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_ISSUE: begin
        if (lo > CNT_BITS'(hi)) begin
          state_next = ST_FIN;
        end else begin
          mid_next   = mid_sum[ADDR_BITS:1];
          req.raddr  = mid_sum[ADDR_BITS:1];
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (rdata == target) begin
          found_next = 1'b1;
          index_next = INDEX_BITS'(mid);
          state_next = ST_FIN;
        end else if (target < rdata) begin
          if (mid == '0) begin
            state_next = ST_FIN;
          end else begin
            hi_next    = mid - ADDR_BITS'(1);
            state_next = ST_ISSUE;
          end
        end else begin
          lo_next    = CNT_BITS'(mid) + CNT_BITS'(1);
          state_next = ST_ISSUE;
        end
      end
      ST_FIN: begin
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {{(OUT_BITS - INDEX_BITS - 1){1'b0}}, index, found};
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      pivot     <= '0;
      descent   <= 1'b0;
      complete  <= 1'b0;
      prev      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pivot     <= pivot_next;
      descent   <= descent_next;
      complete  <= complete_next;
      prev      <= prev_next;
      out_valid <= out_valid_next;
    end
    target   <= target_next;
    lo       <= lo_next;
    hi       <= hi_next;
    mid      <= mid_next;
    found    <= found_next;
    index    <= index_next;
    out_data <= out_data_next;
  end

endmodule

// ===== design/rsas_checker.sv =====
// Port-level checks for the rotated sorted array search block, bound to the top level.
module rsas_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import rsas_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[15:1] == 15'd0)
    else $error("not-found result carries a nonzero index");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == KIND_SEARCH |=> !s_tready)
    else $error("search item did not occupy the block");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind rotated_sorted_array_search rsas_checker u_rsas_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== sim/rotated_sorted_array_search_test.sv =====
// Testbench for rotated_sorted_array_search: load and search streams checked by a built-in predictor.
module rotated_sorted_array_search_test;
  import rsas_pkg::*;

  localparam int RUN_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_LEN      = 900;
  localparam int RANDOM_ITEMS  = 350;
  localparam int QUIET_ITEMS   = 100;
  localparam logic [31:0] MIN_VALUE = 32'h8000_0000;
  localparam logic [31:0] MAX_VALUE = 32'h7fff_ffff;

  typedef struct packed {
    logic        found;
    logic [11:0] index;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  rotated_sorted_array_search dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // predictor state
  value_t store_mem [DEPTH];
  int     arr_len;
  int     pivot;
  bit     has_descent;
  bit     arr_done;
  value_t prev_val;

  answer_t expected_answers[$];
  int      mismatches;
  int      items_sent;
  int      cycle_count;
  int      stall_left;
  bit      quiet;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void absorb_load(value_t v, logic last_flag);
    if (arr_done) begin
      arr_len = 0;
      pivot = 0;
      has_descent = 1'b0;
      arr_done = 1'b0;
    end
    if (arr_len < DEPTH) begin
      if (arr_len > 0 && !has_descent && prev_val > v) begin
        pivot = arr_len - 1;
        has_descent = 1'b1;
      end
      store_mem[arr_len] = v;
      prev_val = v;
      arr_len++;
    end
    if (last_flag) arr_done = 1'b1;
  endfunction

  function automatic int halve_search(int lo, int hi, value_t t);
    int mid;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (store_mem[mid] == t) return mid;
      if (t < store_mem[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  function automatic int locate_target(value_t t);
    int k;
    if (arr_len == 0) return -1;
    if (arr_len == 1) return (store_mem[0] == t) ? 0 : -1;
    if (!has_descent) return halve_search(0, arr_len - 1, t);
    k = pivot;
    if (t < store_mem[k + 1] || t > store_mem[k]) return -1;
    if (t >= store_mem[0] && t <= store_mem[k]) return halve_search(0, k, t);
    if (t >= store_mem[k + 1] && t <= store_mem[arr_len - 1])
      return halve_search(k + 1, arr_len - 1, t);
    return -1;
  endfunction

  // result side: check and random back-pressure
  always @(posedge clk) begin
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual found=%0b index=%0d",
                 $time, m_tdata[0], m_tdata[12:1]);
      end else begin
        want = expected_answers.pop_front();
        if (m_tdata[0] !== want.found) begin
          mismatches++;
          $display("%0t: found mismatch, expected %0b, actual %0b",
                   $time, want.found, m_tdata[0]);
        end
        if (m_tdata[12:1] !== want.index) begin
          mismatches++;
          $display("%0t: index mismatch, expected %0d, actual %0d",
                   $time, want.index, m_tdata[12:1]);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // valid stays high after a handshake; the next call may lower it for a random gap, and a drain lowers it
  task automatic send_item(logic kind, value_t val, logic last_flag);
    int r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= val;
    s_tlast  <= last_flag;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (kind == KIND_LOAD) begin
      absorb_load(val, last_flag);
    end else begin
      r = locate_target(val);
      if (r < 0) expected_answers.push_back(answer_t'('0));
      else expected_answers.push_back(answer_t'{1'b1, r[11:0]});
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_answers.size() != 0) @(posedge clk);
  endtask

  task automatic test_no_array();
    send_item(KIND_SEARCH, 0, 1'b0);
    send_item(KIND_SEARCH, MIN_VALUE, 1'b1);
  endtask

  task automatic test_single_element();
    send_item(KIND_LOAD, 42, 1'b1);
    send_item(KIND_SEARCH, 42, 1'b0);
    send_item(KIND_SEARCH, 41, 1'b0);
  endtask

  task automatic test_rotated_extremes();
    send_item(KIND_LOAD, 0, 1'b0);
    send_item(KIND_LOAD, 1000, 1'b0);
    send_item(KIND_LOAD, MAX_VALUE, 1'b0);
    send_item(KIND_LOAD, MIN_VALUE, 1'b0);
    send_item(KIND_LOAD, -1000, 1'b0);
    send_item(KIND_LOAD, -1, 1'b1);
    send_item(KIND_SEARCH, MIN_VALUE, 1'b0);
    send_item(KIND_SEARCH, MAX_VALUE, 1'b0);
    send_item(KIND_SEARCH, 1000, 1'b0);
    send_item(KIND_SEARCH, -1, 1'b0);
    send_item(KIND_SEARCH, 500, 1'b0);
    send_item(KIND_SEARCH, -500, 1'b0);
  endtask

  // search mid-load, plain ascending array, restart, unsorted contents
  task automatic test_loading_and_restart();
    send_item(KIND_LOAD, -10, 1'b0);
    send_item(KIND_LOAD, -3, 1'b0);
    send_item(KIND_SEARCH, -3, 1'b0);
    send_item(KIND_LOAD, 4, 1'b0);
    send_item(KIND_LOAD, 9, 1'b1);
    send_item(KIND_SEARCH, 9, 1'b0);
    send_item(KIND_SEARCH, 5, 1'b0);
    send_item(KIND_LOAD, 5, 1'b0);
    send_item(KIND_LOAD, 1, 1'b0);
    send_item(KIND_LOAD, 9, 1'b1);
    send_item(KIND_SEARCH, 9, 1'b0);
    send_item(KIND_SEARCH, 1, 1'b0);
  endtask

  // long rotated array: deep binary searches on both segments
  task automatic test_long_array();
    int rot;
    rot = $urandom_range(1, LONG_LEN - 1);
    for (int i = 0; i < LONG_LEN; i++)
      send_item(KIND_LOAD, ((i + rot) % LONG_LEN) * 1000 - 2000000, i == LONG_LEN - 1);
    send_item(KIND_SEARCH, -2000000, 1'b0);
    send_item(KIND_SEARCH, (LONG_LEN - 1) * 1000 - 2000000, 1'b0);
    send_item(KIND_SEARCH, rot * 1000 - 2000000, 1'b0);
    send_item(KIND_SEARCH, 500, 1'b0);
    repeat (4)
      send_item(KIND_SEARCH, $urandom_range(0, LONG_LEN - 1) * 1000 - 2000000, 1'b0);
    drain_results();
  endtask

  task automatic send_random_array();
    int     vals[$];
    longint cur;
    longint step_max;
    int     n;
    int     rot;
    int     j;
    int     a;
    bit     chatty;
    bit     open_end;
    value_t t;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
    case ($urandom_range(0, 2))
      0: step_max = 3;
      1: step_max = 1000;
      default: step_max = 64'd4294967295 / (n + 1);
    endcase
    if ($urandom_range(0, 7) == 0) cur = -64'sd2147483648;
    else if (step_max > 1000)
      cur = -64'sd2147483648 + longint'($urandom_range(0, 32'(step_max)));
    else cur = longint'(int'($urandom));
    while (vals.size() < n && cur <= 64'sd2147483647) begin
      vals.push_back(int'(cur));
      cur += 1 + longint'($urandom_range(0, 32'(step_max - 1)));
    end
    if ($urandom_range(0, 7) == 0 && vals[$] != int'(MAX_VALUE)) vals.push_back(MAX_VALUE);
    n = vals.size();
    // broken order or repeated values now and then
    if ($urandom_range(0, 7) == 0) begin
      j = $urandom_range(0, n - 1);
      a = $urandom_range(0, n - 1);
      t = vals[j];
      vals[j] = vals[a];
      vals[a] = t;
    end
    if ($urandom_range(0, 15) == 0) vals[$urandom_range(0, n - 1)] = vals[$urandom_range(0, n - 1)];
    rot = $urandom_range(0, n - 1);
    chatty = ($urandom_range(0, 9) == 0);
    open_end = ($urandom_range(0, 19) == 0);
    for (int i = 0; i < n; i++) begin
      send_item(KIND_LOAD, vals[(i + rot) % n], open_end ? 1'b0 : (i == n - 1));
      if (chatty && $urandom_range(0, 3) == 0)
        send_item(KIND_SEARCH, vals[$urandom_range(0, n - 1)], 1'b0);
    end
    repeat ($urandom_range(1, 8)) begin
      j = $urandom_range(0, n - 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: t = vals[j];
        6: t = vals[j] + 1;
        7: t = vals[j] - 1;
        8: t = $urandom_range(0, 1) ? MIN_VALUE : MAX_VALUE;
        default: t = $urandom;
      endcase
      send_item(KIND_SEARCH, t, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_streams();
    int first_item;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      quiet = (items_sent - first_item > RANDOM_ITEMS - QUIET_ITEMS);
      case ($urandom_range(0, 19))
        0: send_item(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
        1: drain_results();
        default: send_random_array();
      endcase
    end
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= KIND_LOAD;
    s_tlast  <= 1'b0;
    prev_val = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_no_array();
    test_single_element();
    test_rotated_extremes();
    test_loading_and_restart();
    test_long_array();
    test_random_streams();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== rotated_sorted_array_search.f =====
design/rsas_pkg.sv
design/rsas_store.sv
design/rotated_sorted_array_search.sv
design/rsas_checker.sv
sim/rotated_sorted_array_search_test.sv
